// File: hw/rtl/lfc_pkg.sv
// Shared types and constants of the vehicle lamp flasher control unit.
package lfc_pkg;

  localparam int unsigned NowW    = 32;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned LampW   = 6;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 8;

  localparam logic [PeriodW-1:0] PeriodReset = PeriodW'(1000);

  // Lamp word bit positions.
  localparam int unsigned BitBrake   = 0;
  localparam int unsigned BitReverse = 1;
  localparam int unsigned BitRight   = 2;
  localparam int unsigned BitLeft    = 3;
  localparam int unsigned BitAmber   = 4;
  localparam int unsigned BitHead    = 5;

  typedef enum logic [ModeW-1:0] {
    MODE_MANUAL = 2'd0,
    MODE_AUTO   = 2'd1,
    MODE_HOLD   = 2'd2
  } mode_e;

  typedef struct packed {
    logic             host_headlamp_req;
    logic             host_left_req;
    logic             host_right_req;
    logic             host_reverse_req;
    logic             host_brake_req;
    logic             reverse_switch;
    logic             hand_brake;
    logic             foot_brake;
    logic [ModeW-1:0] vehicle_mode;
    logic [NowW-1:0]  now_ms;
  } item_t;

  typedef struct packed {
    logic [LampW-1:0] lamp_bits;
    logic             flash_active;
    logic [NowW-1:0]  toggle_stamp;
  } lamp_state_t;

endpackage

// File: hw/rtl/lfc_lamp_logic.sv
// Next lamp word and flasher state for one tick.
module lfc_lamp_logic import lfc_pkg::*; #(
  parameter int unsigned PeriodWidth = PeriodW
) (
  input  item_t                  item_i,
  input  lamp_state_t            state_i,
  input  logic [PeriodWidth-1:0] period_i,
  output lamp_state_t            state_o
);

  logic [NowW-1:0]  diff;
  logic             expired;
  logic [1:0]       req;
  logic [1:0]       ind;
  logic [1:0]       ind_d;
  logic             active_d;
  logic [NowW-1:0]  stamp_d;
  logic [LampW-1:0] lamp_d;

  assign diff    = item_i.now_ms - state_i.toggle_stamp;
  assign expired = diff > NowW'(period_i);
  assign req     = {item_i.host_left_req, item_i.host_right_req};
  assign ind     = state_i.lamp_bits[BitLeft:BitRight];

  // Indicator flasher. A dark phase can only end on a later tick, since the
  // stamp is renewed when a lit phase ends.
  always_comb begin
    ind_d    = ind;
    active_d = state_i.flash_active;
    stamp_d  = state_i.toggle_stamp;
    if (req == 2'b00) begin
      ind_d    = 2'b00;
      active_d = 1'b0;
    end else if (!state_i.flash_active) begin
      ind_d    = ind | req;
      active_d = 1'b1;
      stamp_d  = item_i.now_ms;
    end else if (expired) begin
      ind_d   = (ind != 2'b00) ? 2'b00 : req;
      stamp_d = item_i.now_ms;
    end
  end

  always_comb begin
    state_o = state_i;
    case (mode_e'(item_i.vehicle_mode))
      MODE_MANUAL: begin
        lamp_d              = '0;
        lamp_d[BitBrake]    = item_i.foot_brake | item_i.hand_brake;
        lamp_d[BitReverse]  = item_i.reverse_switch;
        state_o.lamp_bits   = lamp_d;
      end
      MODE_AUTO: begin
        lamp_d                  = '0;
        lamp_d[BitBrake]        = item_i.host_brake_req | item_i.foot_brake
                                  | item_i.hand_brake;
        lamp_d[BitReverse]      = item_i.host_reverse_req;
        lamp_d[BitLeft:BitRight] = ind_d;
        lamp_d[BitAmber]        = 1'b1;
        lamp_d[BitHead]         = item_i.host_headlamp_req;
        state_o.lamp_bits       = lamp_d;
        state_o.flash_active    = active_d;
        state_o.toggle_stamp    = stamp_d;
      end
      default: begin
        lamp_d = state_i.lamp_bits;
      end
    endcase
  end

endmodule

// File: hw/rtl/vehicle_lamp_flasher_control_unit.sv
// Top level of the vehicle lamp flasher control unit.
//
// Each item on the input stream is one evaluation tick: tdata carries the
// millisecond time, the vehicle mode and the driver and host request flags.
// For every tick the block returns one item holding the six-bit lamp word.
// The cfg channel writes the flash period in milliseconds; it is always
// ready and should only be written while no tick is in flight.
//
// A tick is captured in an input register, evaluated by one stage of logic
// (a 32-bit subtract and compare for the flasher) and the lamp word lands in
// the output register together with the updated lamp state. The result is
// offered from the output register once the tick has moved on from the input
// register, and one tick is taken every cycle while the receiver keeps up.
// When the receiver stalls, the output register holds its item and the
// input register can still take one more tick; after that tready drops.
// Reset clears the stored lamp word, the flasher state and the valid flags
// of both register stages, and loads a flash period of 1000 ms.
module vehicle_lamp_flasher_control_unit import lfc_pkg::*; #(
  parameter int unsigned PeriodWidth = PeriodW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // now_ms[31:0], vehicle_mode[33:32], foot_brake[34], hand_brake[35],
  // reverse_switch[36], host_brake_req[37], host_reverse_req[38],
  // host_right_req[39], host_left_req[40], host_headlamp_req[41], zeros above
  input  logic [InDataW-1:0]     s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // lamp_word[5:0], zeros above
  output logic [OutDataW-1:0]    m_axis_tdata_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  // flash_period_ms
  input  logic [PeriodWidth-1:0] cfg_data_i
);

  logic [PeriodWidth-1:0] period_q;
  logic                   in_valid_q;
  item_t                  in_item_q;
  logic                   out_valid_q;
  logic [LampW-1:0]       out_lamp_q;
  lamp_state_t            state_q;
  lamp_state_t            state_d;
  logic                   advance;
  logic                   fire;

  assign cfg_ready_o     = 1'b1;
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodWidth'(PeriodReset);
    end else if (cfg_valid_i) begin
      period_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q <= item_t'(s_axis_tdata_i[$bits(item_t)-1:0]);
    end
  end

  lfc_lamp_logic #(
    .PeriodWidth(PeriodWidth)
  ) u_lamp_logic (
    .item_i  (in_item_q),
    .state_i (state_q),
    .period_i(period_q),
    .state_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_lamp_q <= state_d.lamp_bits;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-LampW){1'b0}}, out_lamp_q};

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the vehicle lamp flasher control unit.
`timescale 1ns / 100ps

module tb_top import lfc_pkg::*;;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseTicks   = 75;

  // Mode value three has no package name; the block must treat it as a hold.
  localparam logic [ModeW-1:0] ModeSpare = 2'd3;

  // Request flag masks, laid out as the upper byte of item_t.
  localparam logic [7:0] FlagFoot   = 8'h01;
  localparam logic [7:0] FlagHand   = 8'h02;
  localparam logic [7:0] FlagRevSw  = 8'h04;
  localparam logic [7:0] FlagHBrake = 8'h08;
  localparam logic [7:0] FlagHRev   = 8'h10;
  localparam logic [7:0] FlagRight  = 8'h20;
  localparam logic [7:0] FlagLeft   = 8'h40;
  localparam logic [7:0] FlagHead   = 8'h80;

  class lamp_scoreboard;
    logic [PeriodW-1:0] period;
    logic [LampW-1:0]   lamp;
    logic               flashing;
    logic [NowW-1:0]    stamp;
    logic [LampW-1:0]   expected_words[$];
    int unsigned        errors;
    int unsigned        auto_ticks, manual_ticks, hold_ticks, toggles, checked;

    function new();
      period = PeriodReset;
      lamp = '0;
      flashing = 1'b0;
      stamp = '0;
      errors = 0;
      auto_ticks = 0;
      manual_ticks = 0;
      hold_ticks = 0;
      toggles = 0;
      checked = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Indicator phases end only when the wrapped elapsed time strictly exceeds the period.
    function void step_flasher(logic [NowW-1:0] now, logic right, logic left);
      logic [NowW-1:0] elapsed;
      if (!right && !left) begin
        lamp[BitRight] = 1'b0;
        lamp[BitLeft] = 1'b0;
        flashing = 1'b0;
        return;
      end
      if (!flashing) begin
        lamp[BitRight] = lamp[BitRight] | right;
        lamp[BitLeft] = lamp[BitLeft] | left;
        flashing = 1'b1;
        stamp = now;
        return;
      end
      elapsed = now - stamp;
      if ((lamp[BitRight] || lamp[BitLeft]) && elapsed > NowW'(period)) begin
        lamp[BitRight] = 1'b0;
        lamp[BitLeft] = 1'b0;
        stamp = now;
        toggles++;
      end
      elapsed = now - stamp;
      if (!lamp[BitRight] && !lamp[BitLeft] && elapsed > NowW'(period)) begin
        lamp[BitRight] = right;
        lamp[BitLeft] = left;
        stamp = now;
        toggles++;
      end
    endfunction

    function void note_tick(item_t it);
      if (it.vehicle_mode == MODE_MANUAL) begin
        manual_ticks++;
        lamp[BitAmber] = 1'b0;
        lamp[BitRight] = 1'b0;
        lamp[BitLeft] = 1'b0;
        lamp[BitHead] = 1'b0;
        lamp[BitBrake] = it.foot_brake | it.hand_brake;
        lamp[BitReverse] = it.reverse_switch;
      end else if (it.vehicle_mode == MODE_AUTO) begin
        auto_ticks++;
        lamp[BitAmber] = 1'b1;
        lamp[BitBrake] = it.host_brake_req | it.foot_brake | it.hand_brake;
        lamp[BitReverse] = it.host_reverse_req;
        step_flasher(it.now_ms, it.host_right_req, it.host_left_req);
        lamp[BitHead] = it.host_headlamp_req;
      end else begin
        hold_ticks++;
      end
      expected_words.push_back(lamp);
    endfunction

    function void check_word(logic [OutDataW-1:0] got);
      logic [LampW-1:0] want;
      if (expected_words.size() == 0) begin
        $display("%0t: lamp word %02h arrived with nothing expected", $time, got[LampW-1:0]);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      checked++;
      if (got[LampW-1:0] !== want) begin
        $display("%0t: lamp word mismatch, expected %02h, actual %02h",
                 $time, want, got[LampW-1:0]);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data = '0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [PeriodW-1:0]  cfg_data = '0;

  logic        calm = 1'b0;
  int unsigned cycles = 0;
  int unsigned settings = 0;
  lamp_scoreboard lamp_sb = new();

  always #10 clk_i = ~clk_i;

  vehicle_lamp_flasher_control_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_ready <= calm || ($urandom_range(99) >= 23);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      lamp_sb.check_word(m_data);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_tick(input logic [NowW-1:0] now, input logic [ModeW-1:0] mode,
                           input logic [7:0] flags);
    item_t it;
    it = {flags, mode, now};
    if (!calm && $urandom_range(99) < 23) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= InDataW'(it);
    do @(posedge clk_i); while (!s_ready);
    lamp_sb.note_tick(it);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (lamp_sb.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_period(input logic [PeriodW-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
    lamp_sb.period = value;
    settings++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Mostly autonomous ticks with a sticky indicator request and time steps near
  // the period, so that phases expire and renew; the rest is other modes and jumps.
  task automatic run_phase(input logic [PeriodW-1:0] value);
    logic [NowW-1:0]  now;
    logic [1:0]       req;
    logic [ModeW-1:0] mode;
    logic [7:0]       flags;
    int unsigned      pick, span;
    write_period(value);
    now = $urandom();
    req = 2'($urandom_range(3));
    span = 2 * int'(value) + 3;
    for (int i = 0; i < PhaseTicks; i++) begin
      if ($urandom_range(99) < 8) req = 2'($urandom_range(3));
      pick = $urandom_range(99);
      if (pick < 65) mode = MODE_AUTO;
      else if (pick < 83) mode = MODE_MANUAL;
      else if (pick < 92) mode = MODE_HOLD;
      else mode = ModeSpare;
      if ($urandom_range(99) < 5) now = $urandom();
      else now = now + $urandom_range(0, span);
      flags = 8'($urandom_range(255));
      flags[6:5] = req;
      send_tick(now, mode, flags);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Manual mode lamps from the driver inputs.
    send_tick(32'd0, MODE_MANUAL, 8'h00);
    send_tick(32'd5, MODE_MANUAL, FlagFoot);
    send_tick(32'd6, MODE_MANUAL, FlagHand | FlagRevSw);
    send_tick(32'd7, MODE_MANUAL, 8'hFF);
    // Autonomous flashing at the reset period, including the exact boundary.
    send_tick(32'd100, MODE_AUTO, FlagRight | FlagHead | FlagHBrake);
    send_tick(32'd1100, MODE_AUTO, FlagRight);
    send_tick(32'd1101, MODE_AUTO, FlagRight | FlagLeft);
    send_tick(32'd2101, MODE_AUTO, FlagRight | FlagLeft);
    send_tick(32'd2102, MODE_AUTO, FlagLeft | FlagHRev);
    send_tick(32'd2200, MODE_HOLD, 8'h00);
    send_tick(32'd2300, ModeSpare, 8'hFF);
    // Manual mode darkens the indicators but leaves flashing armed.
    send_tick(32'd2400, MODE_MANUAL, FlagHand);
    send_tick(32'd9000, MODE_AUTO, FlagRight);
    send_tick(32'd9500, MODE_AUTO, 8'h00);
    // Time wrapping through zero and running backwards.
    send_tick(32'hFFFF_FF00, MODE_AUTO, FlagLeft | FlagHead);
    send_tick(32'h0000_0300, MODE_AUTO, FlagLeft);
    send_tick(32'hFFFF_FFFF, MODE_AUTO, FlagLeft);
    send_tick(32'hFFFF_FFFF, MODE_AUTO, 8'hFF);
    send_tick(32'd0, MODE_AUTO, FlagHBrake | FlagHRev | FlagRevSw);

    write_period(16'd1);
    send_tick(32'd10, MODE_AUTO, FlagRight);
    send_tick(32'd11, MODE_AUTO, FlagRight);
    send_tick(32'd12, MODE_AUTO, FlagRight);
    send_tick(32'd14, MODE_AUTO, FlagRight);
    write_period(16'd0);
    send_tick(32'd14, MODE_AUTO, FlagRight);
    send_tick(32'd15, MODE_AUTO, FlagRight);

    run_phase(16'hFFFF);
    run_phase(16'd1);
    calm = 1'b1;
    run_phase(16'd0);
    calm = 1'b0;
    run_phase(16'($urandom_range(0, 65535)));
    run_phase(16'($urandom_range(1, 50)));
    run_phase(PeriodReset);

    drain();
    repeat (8) @(negedge clk_i);
    $display("Checked %0d lamp words from %0d autonomous, %0d manual and %0d holding ticks.",
             lamp_sb.checked, lamp_sb.auto_ticks, lamp_sb.manual_ticks, lamp_sb.hold_ticks);
    $display("Indicators toggled %0d times across %0d flash period settings.",
             lamp_sb.toggles, settings);
    if (lamp_sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/lfc_pkg.sv
hw/rtl/lfc_lamp_logic.sv
hw/rtl/vehicle_lamp_flasher_control_unit.sv
tb/sv/tb_top.sv
